/* rtl/slle_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the static linked list engine
// no dependencies; used by every module of the block
package slle_pkg;

    localparam int NODES      = 64;
    localparam int CAP        = NODES - 2;
    localparam int IDX_W      = 6;
    localparam int LEN_W      = 6;
    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } state_t;

    typedef enum logic [2:0] {
        CM_HOLD   = 3'd0,
        CM_INSERT = 3'd1,
        CM_REMOVE = 3'd2,
        CM_LOAD   = 3'd3,
        CM_SHIFT  = 3'd4
    } cell_mode_t;

    typedef struct packed {
        op_t                           op;
        logic [IDX_W-1:0]              position;
        logic signed [DATA_WIDTH-1:0]  value;
    } request_t;

    typedef struct packed {
        status_t                       status;
        logic [LEN_W-1:0]              length;
        logic signed [DATA_WIDTH-1:0]  read_value;
    } result_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        cell_mode_t                    mode;
        logic [IDX_W-1:0]              pos;
        logic [DATA_WIDTH-1:0]         value;
    } cell_cmd_t;

endpackage

/* rtl/slle_cell.sv */
`timescale 1ns / 1ps
// one list slot: element word plus a read-out register that shifts toward slot 0
// depends on slle_pkg
module slle_cell (
    input  logic                               clk,
    input  slle_pkg::cell_cmd_t                cmd,
    input  logic [slle_pkg::IDX_W-1:0]         index,
    input  logic [slle_pkg::DATA_WIDTH-1:0]    left_data,
    input  logic [slle_pkg::DATA_WIDTH-1:0]    right_data,
    input  logic [slle_pkg::DATA_WIDTH-1:0]    right_rd,
    output logic [slle_pkg::DATA_WIDTH-1:0]    data,
    output logic [slle_pkg::DATA_WIDTH-1:0]    rd
);

    logic [slle_pkg::DATA_WIDTH-1:0] data_reg;
    logic [slle_pkg::DATA_WIDTH-1:0] data_next;
    logic [slle_pkg::DATA_WIDTH-1:0] rd_reg;
    logic [slle_pkg::DATA_WIDTH-1:0] rd_next;

    always_comb
    begin
        data_next = data_reg;
        rd_next   = rd_reg;
        case (cmd.mode)
            slle_pkg::CM_INSERT:
            begin
                // slots past the insert point move one place up
                if (index > cmd.pos)
                begin
                    data_next = left_data;
                end
                else if (index == cmd.pos)
                begin
                    data_next = cmd.value;
                end
            end
            slle_pkg::CM_REMOVE:
            begin
                if (index >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            slle_pkg::CM_LOAD:
            begin
                rd_next = data_reg;
            end
            slle_pkg::CM_SHIFT:
            begin
                rd_next = right_rd;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

/* rtl/slle_ctrl.sv */
`timescale 1ns / 1ps
// control: range checks, element count, read walk counter and result register
// depends on slle_pkg
module slle_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  slle_pkg::request_t                request,
    input  logic [slle_pkg::DATA_WIDTH-1:0]   head_rd,
    output logic                              busy,
    output slle_pkg::cell_cmd_t               cell_cmd,
    output logic                              done,
    output slle_pkg::result_t                 result
);

    slle_pkg::state_t                 state_reg;
    slle_pkg::state_t                 state_next;
    logic [slle_pkg::LEN_W-1:0]       count_reg;
    logic [slle_pkg::LEN_W-1:0]       count_next;
    logic [slle_pkg::IDX_W-1:0]       walk_reg;
    logic [slle_pkg::IDX_W-1:0]       walk_next;
    logic                             done_reg;
    logic                             done_next;
    slle_pkg::result_t                result_reg;
    slle_pkg::result_t                result_next;

    logic                             accept;
    logic                             full;
    slle_pkg::status_t                dec_status;
    slle_pkg::cell_mode_t             dec_mode;
    logic [slle_pkg::IDX_W-1:0]       dec_pos;

    assign accept = start && (state_reg == slle_pkg::S_IDLE);
    assign full   = (count_reg == slle_pkg::LEN_W'(slle_pkg::CAP));

    // decode of the item on the request port
    always_comb
    begin
        dec_status = slle_pkg::ST_OK;
        dec_mode   = slle_pkg::CM_HOLD;
        dec_pos    = request.position;
        case (request.op)
            slle_pkg::OP_APPEND:
            begin
                dec_pos = count_reg;
                if (full)
                begin
                    dec_status = slle_pkg::ST_FULL;
                end
                else
                begin
                    dec_mode = slle_pkg::CM_INSERT;
                end
            end
            slle_pkg::OP_INSERT:
            begin
                if (request.position > count_reg)
                begin
                    dec_status = slle_pkg::ST_BAD_POS;
                end
                else if (full)
                begin
                    dec_status = slle_pkg::ST_FULL;
                end
                else
                begin
                    dec_mode = slle_pkg::CM_INSERT;
                end
            end
            slle_pkg::OP_REMOVE:
            begin
                // one-based position, slot index is one less
                dec_pos = request.position - slle_pkg::IDX_W'(1);
                if (count_reg == '0)
                begin
                    dec_status = slle_pkg::ST_EMPTY;
                end
                else if ((request.position == '0) || (request.position > count_reg))
                begin
                    dec_status = slle_pkg::ST_BAD_POS;
                end
                else
                begin
                    dec_mode = slle_pkg::CM_REMOVE;
                end
            end
            slle_pkg::OP_READ:
            begin
                if (count_reg == '0)
                begin
                    dec_status = slle_pkg::ST_EMPTY;
                end
                else if (request.position >= count_reg)
                begin
                    dec_status = slle_pkg::ST_BAD_POS;
                end
                else
                begin
                    dec_mode = slle_pkg::CM_LOAD;
                end
            end
            default:
            begin
                dec_status = slle_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slle_pkg::S_IDLE:
            begin
                if (accept && (dec_mode == slle_pkg::CM_LOAD))
                begin
                    state_next = slle_pkg::S_WALK;
                end
            end
            slle_pkg::S_WALK:
            begin
                if (walk_reg == '0)
                begin
                    state_next = slle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slle_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        busy           = 1'b0;
        cell_cmd.mode  = slle_pkg::CM_HOLD;
        cell_cmd.pos   = dec_pos;
        cell_cmd.value = request.value;
        count_next     = count_reg;
        walk_next      = walk_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        case (state_reg)
            slle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cell_cmd.mode = dec_mode;
                    if (dec_mode == slle_pkg::CM_INSERT)
                    begin
                        count_next = count_reg + slle_pkg::LEN_W'(1);
                    end
                    else if (dec_mode == slle_pkg::CM_REMOVE)
                    begin
                        count_next = count_reg - slle_pkg::LEN_W'(1);
                    end
                    if (dec_mode == slle_pkg::CM_LOAD)
                    begin
                        walk_next = request.position;
                    end
                    else
                    begin
                        done_next              = 1'b1;
                        result_next.status     = dec_status;
                        result_next.length     = count_next;
                        result_next.read_value = '0;
                    end
                end
            end
            slle_pkg::S_WALK:
            begin
                busy = 1'b1;
                if (walk_reg == '0)
                begin
                    done_next              = 1'b1;
                    result_next.status     = slle_pkg::ST_OK;
                    result_next.length     = count_reg;
                    result_next.read_value = head_rd;
                end
                else
                begin
                    cell_cmd.mode = slle_pkg::CM_SHIFT;
                    walk_next     = walk_reg - slle_pkg::IDX_W'(1);
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slle_pkg::S_IDLE;
            count_reg <= '0;
            walk_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= slle_pkg::LEN_W'(slle_pkg::CAP))
        else $error("element count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == slle_pkg::S_IDLE))
        else $error("result shown while a walk is still running");

    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.op != slle_pkg::OP_READ)) |=> done_reg)
        else $error("non-read item did not finish in one cycle");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status != slle_pkg::ST_OK)) |-> $stable(count_reg))
        else $error("failed item changed the element count");

    a_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slle_pkg::S_IDLE) |-> (walk_reg == '0))
        else $error("walk counter left nonzero");

endmodule

/* rtl/static_linked_list_engine.sv */
`timescale 1ns / 1ps
// append, insert, remove: result strobed in the cycle after the item is taken,
// and a new item may be taken on that same cycle (one item per cycle)
// read at position p: the result follows the walk that loads the read-out words
// and shifts them one cell per cycle down the cell row to slot 0; busy meanwhile
// reset clears the element count and control; slot contents are left as they are
// results cannot be held off: done is high for exactly one cycle per item
module static_linked_list_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  slle_pkg::request_t    request,
    output logic                  busy,
    output logic                  done,
    output slle_pkg::result_t     result
);

    slle_pkg::cell_cmd_t              cell_cmd;
    logic [slle_pkg::DATA_WIDTH-1:0]  cell_data [slle_pkg::CAP];
    logic [slle_pkg::DATA_WIDTH-1:0]  cell_rd   [slle_pkg::CAP];

    slle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .head_rd  (cell_rd[0]),
        .busy     (busy),
        .cell_cmd (cell_cmd),
        .done     (done),
        .result   (result)
    );

    for (genvar i = 0; i < slle_pkg::CAP; i++)
    begin : g_cell
        logic [slle_pkg::DATA_WIDTH-1:0] left_data;
        logic [slle_pkg::DATA_WIDTH-1:0] right_data;
        logic [slle_pkg::DATA_WIDTH-1:0] right_rd;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == slle_pkg::CAP - 1)
        begin : g_last
            assign right_data = '0;
            assign right_rd   = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
            assign right_rd   = cell_rd[i+1];
        end

        slle_cell u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .index      (slle_pkg::IDX_W'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .right_rd   (right_rd),
            .data       (cell_data[i]),
            .rd         (cell_rd[i])
        );
    end

endmodule

/* tb/slle_list_monitor.sv */
`timescale 1ns / 1ps
// result monitor for the static linked list engine: mirrors the list contents,
// predicts each item's result and compares it with what the block returns
// depends on slle_pkg for the request and result types
module slle_list_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  slle_pkg::request_t             request,
    input  logic                           done,
    input  slle_pkg::result_t              result,
    output int                             errors,
    output int                             pending,
    output logic [slle_pkg::LEN_W-1:0]     list_len
);

    // list contents in order, head first
    logic signed [slle_pkg::DATA_WIDTH-1:0] list_vals[$];
    slle_pkg::result_t                      expected_results[$];
    slle_pkg::result_t                      want;
    int                                     err_count  = 0;
    int                                     pend_count = 0;
    logic [slle_pkg::LEN_W-1:0]             len_q      = '0;

    assign errors   = err_count;
    assign pending  = pend_count;
    assign list_len = len_q;

    task automatic report_mismatch(input string msg);
        $display("%0t slle_list_monitor: %s", $time, msg);
        err_count++;
    endtask

    function automatic slle_pkg::result_t apply_list_op(input slle_pkg::request_t req);
        slle_pkg::result_t r;
        int unsigned       cnt;
        cnt          = list_vals.size();
        r.status     = slle_pkg::ST_OK;
        r.read_value = '0;
        case (req.op)
            slle_pkg::OP_APPEND:
                if (cnt == slle_pkg::CAP)
                    r.status = slle_pkg::ST_FULL;
                else
                    list_vals = {list_vals, req.value};
            slle_pkg::OP_INSERT:
                // position is checked before capacity
                if (req.position > cnt)
                    r.status = slle_pkg::ST_BAD_POS;
                else if (cnt == slle_pkg::CAP)
                    r.status = slle_pkg::ST_FULL;
                else
                    list_vals.insert(req.position, req.value);
            slle_pkg::OP_REMOVE:
                if (cnt == 0)
                    r.status = slle_pkg::ST_EMPTY;
                else if (req.position == 0 || req.position > cnt)
                    r.status = slle_pkg::ST_BAD_POS;
                else
                    list_vals.delete(req.position - 1);
            slle_pkg::OP_READ:
                if (cnt == 0)
                    r.status = slle_pkg::ST_EMPTY;
                else if (req.position >= cnt)
                    r.status = slle_pkg::ST_BAD_POS;
                else
                    r.read_value = list_vals[req.position];
            default:
                r.status = slle_pkg::ST_OK;
        endcase
        r.length = slle_pkg::LEN_W'(list_vals.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result always belongs to an earlier item, so check before taking a new one
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  result.status, want.status));
                    if (result.length !== want.length)
                        report_mismatch($sformatf("length got %0d want %0d",
                                                  result.length, want.length));
                    if (result.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %0h want %0h",
                                                  result.read_value, want.read_value));
                end
            end
            if (start && busy === 1'b0)
                expected_results = {expected_results, apply_list_op(request)};
            pend_count = expected_results.size();
            len_q      = slle_pkg::LEN_W'(list_vals.size());
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// top of the static linked list engine testbench: clock, reset, item stimulus
// depends on slle_pkg, static_linked_list_engine and slle_list_monitor
module tb_top;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } op_mix_t;

    logic                          clk     = 1'b0;
    logic                          rst_n   = 1'b0;
    logic                          start   = 1'b0;
    slle_pkg::request_t            request = '0;
    logic                          busy;
    logic                          done;
    slle_pkg::result_t             result;
    int                            errors;
    int                            pending;
    logic [slle_pkg::LEN_W-1:0]    list_len;
    logic [slle_pkg::LEN_W-1:0]    len_hint = '0;

    static_linked_list_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    slle_list_monitor mon (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .errors   (errors),
        .pending  (pending),
        .list_len (list_len)
    );

    always #5 clk = ~clk;

    // length seen by the generator only, sampled away from the active edge
    always @(negedge clk)
        len_hint <= list_len;

    function automatic slle_pkg::request_t mk(input slle_pkg::op_t op, input int pos,
                                              input logic [31:0] val);
        slle_pkg::request_t r;
        r.op       = op;
        r.position = slle_pkg::IDX_W'(pos);
        r.value    = val;
        return r;
    endfunction

    function automatic slle_pkg::request_t rand_item(input op_mix_t mix);
        slle_pkg::request_t r;
        int                 pick;
        pick = $urandom_range(99);
        case (mix)
            MIX_GROW:
                if (pick < 40)
                    r.op = slle_pkg::OP_APPEND;
                else if (pick < 70)
                    r.op = slle_pkg::OP_INSERT;
                else if (pick < 80)
                    r.op = slle_pkg::OP_REMOVE;
                else
                    r.op = slle_pkg::OP_READ;
            MIX_SHRINK:
                if (pick < 10)
                    r.op = slle_pkg::OP_APPEND;
                else if (pick < 20)
                    r.op = slle_pkg::OP_INSERT;
                else if (pick < 65)
                    r.op = slle_pkg::OP_REMOVE;
                else
                    r.op = slle_pkg::OP_READ;
            default:
                r.op = slle_pkg::op_t'($urandom_range(3));
        endcase
        if ($urandom_range(4) == 0)
            r.position = slle_pkg::IDX_W'($urandom_range(63));
        else
            r.position = slle_pkg::IDX_W'($urandom_range(int'(len_hint) + 1));
        case ($urandom_range(9))
            0:       r.value = 32'h7fff_ffff;
            1:       r.value = 32'h8000_0000;
            2:       r.value = 32'h0;
            3:       r.value = 32'hffff_ffff;
            default: r.value = $urandom;
        endcase
        return r;
    endfunction

    // called at a rising edge; returns at the edge that took the item
    task automatic issue_item(input slle_pkg::request_t req, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        op_mix_t  mixes[6];
        int       idle_pcts[6];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases, then a short list with extreme values
        issue_item(mk(slle_pkg::OP_READ,   0,  32'h1), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 1,  32'h2), 0);
        issue_item(mk(slle_pkg::OP_INSERT, 1,  32'h3), 0);
        issue_item(mk(slle_pkg::OP_APPEND, 0,  32'h7fff_ffff), 0);
        issue_item(mk(slle_pkg::OP_APPEND, 0,  32'h8000_0000), 0);
        issue_item(mk(slle_pkg::OP_INSERT, 0,  32'hffff_ffff), 0);
        // insert at the current length lands at the tail
        issue_item(mk(slle_pkg::OP_INSERT, 3,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_INSERT, 63, 32'h1234_5678), 0);
        for (int i = 0; i < 4; i++)
            issue_item(mk(slle_pkg::OP_READ, i, 32'hdead_beef), 0);
        issue_item(mk(slle_pkg::OP_READ,   4,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_READ,   63, 32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 0,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 5,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 2,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 3,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 1,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_READ,   0,  32'h0), 0);
        // position is don't-care for append
        issue_item(mk(slle_pkg::OP_APPEND, 63, 32'h5555_aaaa), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 1,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 1,  32'h0), 0);
        issue_item(mk(slle_pkg::OP_REMOVE, 1,  32'h0), 0);
        wait_all_results();

        // grow phases run the list into the full case
        mixes     = '{MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_GROW, MIX_EVEN, MIX_SHRINK};
        idle_pcts = '{0, 63, 15, 63, 15, 0};
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int n = 0; n < 250; n++)
                issue_item(rand_item(mixes[ph]), idle_pcts[ph]);
            wait_all_results();
        end

        repeat (70) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
